[rtl/core/plsc_pkg.sv]
// Package for the positional list store core: command codes, cell edit codes
// and the response record shared by the cell chain and the top level.
// No dependencies.
package plsc_pkg;

   localparam int CMD_W      = 4;
   localparam int POS_W      = 7;
   localparam int DATA_W     = 32;
   localparam int RSP_IDX_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 4'd0,
      CMD_PUSH_BACK  = 4'd1,
      CMD_POP_FRONT  = 4'd2,
      CMD_POP_BACK   = 4'd3,
      CMD_INSERT     = 4'd4,
      CMD_ERASE      = 4'd5,
      CMD_FIND       = 4'd6,
      CMD_READ       = 4'd7,
      CMD_WRITE      = 4'd8,
      CMD_CLEAR      = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      EDIT_NONE   = 2'd0,
      EDIT_INSERT = 2'd1,
      EDIT_ERASE  = 2'd2,
      EDIT_WRITE  = 2'd3
   } edit_type;

   typedef struct packed {
      logic                 ok;
      logic [DATA_W-1:0]    read_value;
      logic [RSP_IDX_W-1:0] found_index;
      logic [RSP_IDX_W-1:0] count;
      logic [DATA_W-1:0]    front_value;
      logic [DATA_W-1:0]    back_value;
   } rsp_type;

endpackage

[rtl/core/plsc_cell.sv]
// One storage cell of the list chain: holds one entry and takes its neighbor's
// entry on insert or erase shifts. Depends on plsc_pkg.
module plsc_cell #(
   parameter int DW    = 32,
   parameter int PW    = 7,
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  plsc_pkg::edit_type edit_kind,
   input  logic [PW-1:0]      edit_pos,
   input  logic [DW-1:0]      edit_value,
   input  logic [DW-1:0]      left_value,
   input  logic [DW-1:0]      right_value,
   output logic [DW-1:0]      cell_value
);
   import plsc_pkg::*;

   localparam logic [PW-1:0] IDX = PW'(INDEX);

   logic [DW-1:0] value_ff;
   logic [DW-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (edit_kind)
         EDIT_INSERT: begin
            if (IDX > edit_pos) begin
               value_in = left_value;
            end else if (IDX == edit_pos) begin
               value_in = edit_value;
            end
         end
         EDIT_ERASE: begin
            if (IDX >= edit_pos) begin
               value_in = right_value;
            end
         end
         EDIT_WRITE: begin
            if (IDX == edit_pos) begin
               value_in = edit_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;

endmodule

[rtl/core/plsc_pick_tree.sv]
// Registered priority tree over the cell row: picks the lowest leaf with
// hit_a (index and data) and the data of the lowest leaf with hit_b.
// Depends on plsc_pkg.
module plsc_pick_tree #(
   parameter int LEAVES = 64,
   parameter int DW     = 32
) (
   input  logic                         clock,
   input  logic                         leaf_hit_a [LEAVES],
   input  logic                         leaf_hit_b [LEAVES],
   input  logic [DW-1:0]                leaf_data  [LEAVES],
   output logic                         root_hit_a,
   output logic [$clog2(LEAVES)-1:0]    root_idx_a,
   output logic [DW-1:0]                root_data_a,
   output logic [DW-1:0]                root_data_b
);
   import plsc_pkg::*;

   localparam int LEVELS = $clog2(LEAVES);
   localparam int SPAN   = 1 << LEVELS;
   localparam int NODES  = 2 * SPAN - 1;

   logic              ha_ff [NODES];
   logic              hb_ff [NODES];
   logic [LEVELS-1:0] ia_ff [NODES];
   logic [DW-1:0]     da_ff [NODES];
   logic [DW-1:0]     db_ff [NODES];

   for (genvar j = 0; j < SPAN; j++) begin : g_leaf
      if (j < LEAVES) begin : g_real
         always_ff @(posedge clock) begin
            ha_ff[SPAN-1+j] <= leaf_hit_a[j];
            hb_ff[SPAN-1+j] <= leaf_hit_b[j];
            ia_ff[SPAN-1+j] <= LEVELS'(j);
            da_ff[SPAN-1+j] <= leaf_data[j];
            db_ff[SPAN-1+j] <= leaf_data[j];
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            ha_ff[SPAN-1+j] <= 1'b0;
            hb_ff[SPAN-1+j] <= 1'b0;
            ia_ff[SPAN-1+j] <= LEVELS'(j);
            da_ff[SPAN-1+j] <= '0;
            db_ff[SPAN-1+j] <= '0;
         end
      end
   end

   for (genvar n = 0; n < SPAN - 1; n++) begin : g_node
      always_ff @(posedge clock) begin
         ha_ff[n] <= ha_ff[2*n+1] | ha_ff[2*n+2];
         hb_ff[n] <= hb_ff[2*n+1] | hb_ff[2*n+2];
         ia_ff[n] <= ha_ff[2*n+1] ? ia_ff[2*n+1] : ia_ff[2*n+2];
         da_ff[n] <= ha_ff[2*n+1] ? da_ff[2*n+1] : da_ff[2*n+2];
         db_ff[n] <= hb_ff[2*n+1] ? db_ff[2*n+1] : db_ff[2*n+2];
      end
   end

   assign root_hit_a  = ha_ff[0];
   assign root_idx_a  = ia_ff[0];
   assign root_data_a = da_ff[0];
   assign root_data_b = db_ff[0];

endmodule

[rtl/core/positional_list_store_core.sv]
// Positional list store: a chain of CAPACITY cells that shift on insert and erase.
// The response comes out of the registered selection tree that reads find, read and back
// out of the cells; a new request is held off until the previous one reaches the output.
// A finished response waits in a two-entry output stage. Reset clears the count and
// the handshake; cells keep data.
module positional_list_store_core #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [plsc_pkg::CMD_W-1:0]           req_command,
   input  logic [plsc_pkg::POS_W-1:0]           req_position,
   input  logic signed [plsc_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_ok,
   output logic signed [plsc_pkg::DATA_W-1:0]   rsp_read_value,
   output logic [plsc_pkg::RSP_IDX_W-1:0]       rsp_found_index,
   output logic [plsc_pkg::RSP_IDX_W-1:0]       rsp_count,
   output logic signed [plsc_pkg::DATA_W-1:0]   rsp_front_value,
   output logic signed [plsc_pkg::DATA_W-1:0]   rsp_back_value
);
   import plsc_pkg::*;

   localparam int DW     = (VALUE_WIDTH > DATA_W) ? DATA_W : VALUE_WIDTH;
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int PW     = (CW > POS_W) ? CW : POS_W;
   localparam int LEVELS = $clog2(CAPACITY);
   localparam logic [PW-1:0] CAP_EXT = PW'(CAPACITY);

   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [LEVELS+1:0] pipe_ff;
   logic              req_acc;
   logic              done;

   logic              fnd_ff;
   logic              rd_ff;
   logic              ok_ff;
   logic [PW-1:0]     pos_ff;
   logic [DW-1:0]     val_ff;

   logic [PW-1:0]     count_ext;
   logic [PW-1:0]     pos_ext;
   logic [DW-1:0]     val_req;
   logic [PW-1:0]     ins_pos;
   logic [PW-1:0]     del_pos;
   logic [PW-1:0]     edit_pos;
   edit_type          kind;
   edit_type          cell_kind;
   logic              ok_in;
   logic              fnd_in;
   logic              rd_in;

   logic [DW-1:0]     cell_value [CAPACITY];
   logic              leaf_hit_a [CAPACITY];
   logic              leaf_hit_b [CAPACITY];

   logic              root_hit_a;
   logic [LEVELS-1:0] root_idx_a;
   logic [DW-1:0]     root_data_a;
   logic [DW-1:0]     root_data_b;

   rsp_type           res;
   logic [PW-1:0]     fidx;
   rsp_type           out_ff;
   logic              out_vld_ff;
   rsp_type           pend_ff;
   logic              pend_vld_ff;
   logic              out_free;

   assign req_stall = (|pipe_ff[LEVELS:0]) | pend_vld_ff | (done & out_vld_ff);
   assign req_acc   = req_valid & ~req_stall;
   assign done      = pipe_ff[LEVELS+1];

   assign count_ext = PW'(count_ff);
   assign pos_ext   = PW'(req_position);
   assign val_req   = req_value[DW-1:0];

   always_comb begin
      ins_pos  = pos_ext;
      del_pos  = pos_ext;
      edit_pos = pos_ext;
      kind     = EDIT_NONE;
      ok_in    = 1'b0;
      fnd_in   = 1'b0;
      rd_in    = 1'b0;
      count_in = count_ff;
      case (cmd_type'(req_command))
         CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
            if (cmd_type'(req_command) == CMD_PUSH_FRONT) begin
               ins_pos = '0;
            end else if (cmd_type'(req_command) == CMD_PUSH_BACK) begin
               ins_pos = count_ext;
            end
            edit_pos = ins_pos;
            if (count_ext < CAP_EXT && ins_pos <= count_ext) begin
               kind     = EDIT_INSERT;
               ok_in    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE: begin
            if (cmd_type'(req_command) == CMD_POP_FRONT) begin
               del_pos = '0;
            end else if (cmd_type'(req_command) == CMD_POP_BACK) begin
               del_pos = (count_ff != '0) ? count_ext - PW'(1) : '0;
            end
            edit_pos = del_pos;
            if (count_ff != '0 && del_pos < count_ext) begin
               kind     = EDIT_ERASE;
               ok_in    = 1'b1;
               count_in = count_ff - CW'(1);
            end
         end
         CMD_FIND: begin
            ok_in  = 1'b1;
            fnd_in = 1'b1;
         end
         CMD_READ: begin
            if (pos_ext < count_ext) begin
               ok_in = 1'b1;
               rd_in = 1'b1;
            end
         end
         CMD_WRITE: begin
            if (pos_ext < count_ext) begin
               kind  = EDIT_WRITE;
               ok_in = 1'b1;
            end
         end
         CMD_CLEAR: begin
            ok_in    = 1'b1;
            count_in = '0;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   assign cell_kind = req_acc ? kind : EDIT_NONE;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DW-1:0] left_value;
      logic [DW-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_l
         assign left_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_mid_r
         assign right_value = cell_value[i+1];
      end

      plsc_cell #(
         .DW    (DW),
         .PW    (PW),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .edit_kind   (cell_kind),
         .edit_pos    (edit_pos),
         .edit_value  (val_req),
         .left_value  (left_value),
         .right_value (right_value),
         .cell_value  (cell_value[i])
      );

      assign leaf_hit_a[i] = (PW'(i) < count_ext)
                           & (fnd_ff ? (cell_value[i] == val_ff) : (PW'(i) == pos_ff));
      assign leaf_hit_b[i] = (PW'(i + 1) == count_ext);
   end

   plsc_pick_tree #(
      .LEAVES (CAPACITY),
      .DW     (DW)
   ) u_tree (
      .clock       (clock),
      .leaf_hit_a  (leaf_hit_a),
      .leaf_hit_b  (leaf_hit_b),
      .leaf_data   (cell_value),
      .root_hit_a  (root_hit_a),
      .root_idx_a  (root_idx_a),
      .root_data_a (root_data_a),
      .root_data_b (root_data_b)
   );

   always_comb begin
      fidx            = fnd_ff ? (root_hit_a ? PW'(root_idx_a) : count_ext) : '0;
      res.ok          = ok_ff;
      res.read_value  = rd_ff ? DATA_W'(root_data_a) : '0;
      res.found_index = fidx[RSP_IDX_W-1:0];
      res.count       = count_ext[RSP_IDX_W-1:0];
      res.front_value = (count_ff != '0) ? DATA_W'(cell_value[0]) : '0;
      res.back_value  = (count_ff != '0) ? DATA_W'(root_data_b) : '0;
   end

   assign out_free = ~out_vld_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         fnd_ff <= fnd_in;
         rd_ff  <= rd_in;
         ok_ff  <= ok_in;
         pos_ff <= pos_ext;
         val_ff <= val_req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         pipe_ff     <= '0;
         out_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         pipe_ff <= {pipe_ff[LEVELS:0], req_acc};
         if (req_acc) begin
            count_ff <= count_in;
         end
         if (pend_vld_ff) begin
            if (out_free) begin
               out_ff      <= pend_ff;
               out_vld_ff  <= 1'b1;
               pend_vld_ff <= 1'b0;
            end
         end else if (done) begin
            if (out_free) begin
               out_ff     <= res;
               out_vld_ff <= 1'b1;
            end else begin
               pend_ff     <= res;
               pend_vld_ff <= 1'b1;
            end
         end else if (out_vld_ff && !rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_ok          = out_ff.ok;
   assign rsp_read_value  = out_ff.read_value;
   assign rsp_found_index = out_ff.found_index;
   assign rsp_count       = out_ff.count;
   assign rsp_front_value = out_ff.front_value;
   assign rsp_back_value  = out_ff.back_value;

endmodule

[verif/tb_positional_list_store_core.sv]
// Testbench for positional_list_store_core: directed table then random command episodes,
// each response checked in request order against a queue-based list predictor or a row's want.
// Depends on plsc_pkg and the positional_list_store_core RTL.
module tb_positional_list_store_core;
   import plsc_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int LATENCY     = $clog2(CAPACITY) + 2;
   localparam int RANDOM_REQS = 1200;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 600;

   localparam logic [CMD_W-1:0]  CMD_SPARE_FIRST = 4'd10;
   localparam logic [CMD_W-1:0]  CMD_SPARE_LAST  = 4'd15;
   localparam logic [DATA_W-1:0] VALUE_MAX       = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] VALUE_MIN       = 32'h8000_0000;

   typedef enum {MIX_GROW, MIX_SHRINK, MIX_BLEND, MIX_NOISE} mix_type;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      bit                typed;
      rsp_type           want;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_ok;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [RSP_IDX_W-1:0]     rsp_found_index;
   logic [RSP_IDX_W-1:0]     rsp_count;
   logic signed [DATA_W-1:0] rsp_front_value;
   logic signed [DATA_W-1:0] rsp_back_value;

   logic [DATA_W-1:0] list_image[$];
   rsp_type           pending_responses[$];
   stim_row_type      directed_rows[$];
   int                mismatches = 0;
   int                responses_checked = 0;
   int                cycle_count = 0;

   positional_list_store_core #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (DATA_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ok          (rsp_ok),
      .rsp_read_value  (rsp_read_value),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic rsp_type apply_list_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [DATA_W-1:0] val);
      rsp_type r;
      int      n;
      int      where;
      r = '0;
      n = list_image.size();
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
            where = (cmd == CMD_PUSH_FRONT) ? 0 : (cmd == CMD_PUSH_BACK) ? n : int'(pos);
            if (n < CAPACITY && where <= n) begin
               list_image.insert(where, val);
               r.ok = 1'b1;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE: begin
            where = (cmd == CMD_POP_FRONT) ? 0 : (cmd == CMD_POP_BACK) ? n - 1 : int'(pos);
            if (n > 0 && where >= 0 && where < n) begin
               list_image.delete(where);
               r.ok = 1'b1;
            end
         end
         CMD_FIND: begin
            r.found_index = RSP_IDX_W'(n);
            for (int i = n - 1; i >= 0; i--)
               if (list_image[i] == val) r.found_index = RSP_IDX_W'(i);
            r.ok = 1'b1;
         end
         CMD_READ: begin
            if (int'(pos) < n) begin
               r.read_value = list_image[pos];
               r.ok = 1'b1;
            end
         end
         CMD_WRITE: begin
            if (int'(pos) < n) begin
               list_image[pos] = val;
               r.ok = 1'b1;
            end
         end
         CMD_CLEAR: begin
            list_image.delete();
            r.ok = 1'b1;
         end
         default: ;
      endcase
      n = list_image.size();
      r.count = RSP_IDX_W'(n);
      if (n > 0) begin
         r.front_value = list_image[0];
         r.back_value  = list_image[n-1];
      end
      return r;
   endfunction

   function automatic rsp_type known(input logic ok, input logic [RSP_IDX_W-1:0] cnt,
                                     input logic [DATA_W-1:0] front,
                                     input logic [DATA_W-1:0] back);
      rsp_type r;
      r = '0;
      r.ok          = ok;
      r.count       = cnt;
      r.front_value = front;
      r.back_value  = back;
      return r;
   endfunction

   task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                          input logic [DATA_W-1:0] val, input bit typed, input rsp_type want);
      stim_row_type row;
      row.cmd   = cmd;
      row.pos   = pos;
      row.val   = val;
      row.typed = typed;
      row.want  = want;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] val, input bit typed,
                               input rsp_type want);
      rsp_type predicted;
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (req_stall);
      predicted = apply_list_command(cmd, pos, val);
      pending_responses.insert(pending_responses.size(), typed ? want : predicted);
   endtask

   task automatic idle_sender(input int rate);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < rate)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      int n;
      int p;
      n = list_image.size();
      p = $urandom_range(0, 9);
      if (p < 4) return $urandom;
      if (p < 7 && n > 0) return list_image[$urandom_range(0, n - 1)];
      if (p < 9) return DATA_W'($signed($urandom_range(0, 7)) - 4);
      case ($urandom_range(0, 3))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2:       return '1;
         default: return '0;
      endcase
   endfunction

   task automatic make_request(input mix_type mix, output logic [CMD_W-1:0] cmd,
                               output logic [POS_W-1:0] pos, output logic [DATA_W-1:0] val);
      int n;
      int p;
      n = list_image.size();
      p = $urandom_range(0, 99);
      case (mix)
         MIX_GROW: begin
            if      (p < 20) cmd = CMD_PUSH_FRONT;
            else if (p < 40) cmd = CMD_PUSH_BACK;
            else if (p < 70) cmd = CMD_INSERT;
            else if (p < 78) cmd = CMD_FIND;
            else if (p < 86) cmd = CMD_READ;
            else if (p < 94) cmd = CMD_WRITE;
            else if (p < 97) cmd = CMD_ERASE;
            else             cmd = CMD_POP_BACK;
         end
         MIX_SHRINK: begin
            if      (p < 20) cmd = CMD_POP_FRONT;
            else if (p < 40) cmd = CMD_POP_BACK;
            else if (p < 65) cmd = CMD_ERASE;
            else if (p < 75) cmd = CMD_FIND;
            else if (p < 85) cmd = CMD_READ;
            else if (p < 92) cmd = CMD_WRITE;
            else if (p < 98) cmd = CMD_PUSH_BACK;
            else             cmd = CMD_CLEAR;
         end
         MIX_BLEND: cmd = (p < 3) ? CMD_CLEAR : CMD_W'($urandom_range(0, 8));
         default:   cmd = CMD_W'($urandom_range(0, 15));
      endcase
      if (mix == MIX_NOISE || $urandom_range(0, 9) == 0)
         pos = POS_W'($urandom_range(0, 127));
      else if (cmd == CMD_INSERT)
         pos = POS_W'($urandom_range(0, n));
      else if (n > 0)
         pos = POS_W'($urandom_range(0, n - 1));
      else
         pos = '0;
      val = pick_value();
   endtask

   task automatic check_response();
      rsp_type want;
      if (pending_responses.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: ok %0b count %0d", rsp_ok, rsp_count);
         return;
      end
      want = pending_responses[0];
      pending_responses.delete(0);
      responses_checked++;
      if (rsp_ok !== want.ok || rsp_read_value !== want.read_value ||
          rsp_found_index !== want.found_index || rsp_count !== want.count ||
          rsp_front_value !== want.front_value || rsp_back_value !== want.back_value) begin
         mismatches++;
         if (mismatches <= 10) begin
            $write("response %0d mismatch: expected ok %0b rd %h idx %0d",
                   responses_checked, want.ok, want.read_value, want.found_index);
            $write(" cnt %0d front %h back %h,", want.count, want.front_value,
                   want.back_value);
            $write(" got ok %0b rd %h idx %0d", rsp_ok, rsp_read_value, rsp_found_index);
            $display(" cnt %0d front %h back %h", rsp_count, rsp_front_value,
                     rsp_back_value);
         end
      end
   endtask

   initial begin : response_side
      int  stall_left;
      int  rate;
      int  local_cycles;
      bit  held;
      stall_left   = 0;
      rate         = 20;
      local_cycles = 0;
      held         = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         local_cycles++;
         if (!reset && rsp_valid && !rsp_stall) check_response();
         if (local_cycles % 200 == 0)
            rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
         if (!held && responses_checked >= 300) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && $urandom_range(0, 99) < rate) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   initial begin : request_side
      logic [CMD_W-1:0]  cmd;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      mix_type           mix;
      int                issued;
      int                span;
      int                rate;
      bit                paused;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_command  <= CMD_FIND;
      req_position <= '0;
      req_value    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(CMD_POP_FRONT,  7'd0,   '0,        1'b1, known(1'b0, 7'd0, '0, '0));
      add_row(CMD_POP_BACK,   7'd0,   '0,        1'b1, known(1'b0, 7'd0, '0, '0));
      add_row(CMD_FIND,       7'd0,   32'd5,     1'b1, known(1'b1, 7'd0, '0, '0));
      add_row(CMD_READ,       7'd0,   '0,        1'b1, known(1'b0, 7'd0, '0, '0));
      add_row(CMD_WRITE,      7'd0,   32'd9,     1'b1, known(1'b0, 7'd0, '0, '0));
      add_row(CMD_ERASE,      7'd0,   '0,        1'b1, known(1'b0, 7'd0, '0, '0));
      add_row(CMD_INSERT,     7'd1,   32'd3,     1'b1, known(1'b0, 7'd0, '0, '0));
      add_row(CMD_INSERT,     7'd127, 32'd3,     1'b1, known(1'b0, 7'd0, '0, '0));
      add_row(CMD_PUSH_BACK,  7'd0,   VALUE_MAX, 1'b1, known(1'b1, 7'd1, VALUE_MAX, VALUE_MAX));
      add_row(CMD_PUSH_FRONT, 7'd0,   VALUE_MIN, 1'b1, known(1'b1, 7'd2, VALUE_MIN, VALUE_MAX));
      add_row(CMD_INSERT,     7'd2,   '1,        1'b0, '0);
      add_row(CMD_INSERT,     7'd0,   '0,        1'b0, '0);
      add_row(CMD_INSERT,     7'd2,   32'h5555_5555, 1'b0, '0);
      add_row(CMD_FIND,       7'd0,   '1,        1'b0, '0);
      add_row(CMD_FIND,       7'd0,   32'd12345, 1'b0, '0);
      add_row(CMD_FIND,       7'd0,   '0,        1'b0, '0);
      add_row(CMD_READ,       7'd4,   '0,        1'b0, '0);
      add_row(CMD_READ,       7'd5,   '0,        1'b0, '0);
      add_row(CMD_WRITE,      7'd1,   32'hAAAA_AAAA, 1'b0, '0);
      add_row(CMD_WRITE,      7'd5,   32'd7,     1'b0, '0);
      add_row(CMD_ERASE,      7'd2,   '0,        1'b0, '0);
      add_row(CMD_ERASE,      7'd4,   '0,        1'b0, '0);
      add_row(CMD_SPARE_FIRST, 7'd0,  32'd1,     1'b0, '0);
      add_row(CMD_SPARE_LAST, 7'd127, '1,        1'b0, '0);
      add_row(CMD_POP_BACK,   7'd0,   '0,        1'b0, '0);
      add_row(CMD_POP_FRONT,  7'd0,   '0,        1'b0, '0);
      add_row(CMD_CLEAR,      7'd0,   '0,        1'b1, known(1'b1, 7'd0, '0, '0));

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].val,
                      directed_rows[i].typed, directed_rows[i].want);
         idle_sender(30);
      end
      drain_responses();

      issued = 0;
      paused = 1'b0;
      while (issued < RANDOM_REQS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: mix = MIX_GROW;
            4, 5, 6:    mix = MIX_SHRINK;
            7, 8:       mix = MIX_BLEND;
            default:    mix = MIX_NOISE;
         endcase
         span = (mix == MIX_GROW) ? $urandom_range(20, 120) : $urandom_range(10, 60);
         rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         for (int k = 0; k < span && issued < RANDOM_REQS; k++) begin
            make_request(mix, cmd, pos, val);
            send_request(cmd, pos, val, 1'b0, '0);
            issued++;
            if (!paused && issued >= RANDOM_REQS / 2) begin
               paused = 1'b1;
               drain_responses();
            end else begin
               idle_sender(rate);
            end
         end
      end

      drain_responses();
      repeat (4 * LATENCY) @(posedge clock);
      if (mismatches == 0 && pending_responses.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
